@@ rtl/ldf_pkg.sv @@
// Package for the lidar packet deframer: payload types, record codes and
// frame layout constants. No dependencies.
package ldf_pkg;

  // Default frame geometry
  localparam int unsigned DefBlocksPerPacket = 12;
  localparam int unsigned DefReturnsPerBlock = 32;

  // Block layout: id (2 bytes), rotation (2 bytes), then 3-byte returns
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned ReturnBytes = 3;
  localparam int unsigned RotLoPos    = 2;
  localparam int unsigned RotHiPos    = 3;

  // Tail: 4 timestamp bytes then 2 ignored bytes
  localparam int unsigned TailBytes   = 6;
  localparam int unsigned TsLastByte  = 3;
  localparam int unsigned TailCntW    = 3;

  // Return counter wraps at 32 regardless of geometry
  localparam int unsigned RetCntW     = 5;

  localparam logic [15:0] MinRangeRawReset = 16'd450;

  typedef enum logic [0:0] {
    REC_RETURN    = 1'b0,
    REC_TIMESTAMP = 1'b1
  } record_kind_e;

  // Byte role inside one return
  typedef enum logic [1:0] {
    SUB_DIST_LO = 2'd0,
    SUB_DIST_HI = 2'd1,
    SUB_INTENS  = 2'd2
  } ret_sub_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } ldf_in_item_t;

  typedef struct packed {
    record_kind_e record_kind;
    logic [5:0]   laser_index;
    logic [2:0]   column_index;
    logic [15:0]  rotation_centideg;
    logic [16:0]  distance_mm;
    logic [7:0]   intensity;
    logic [31:0]  timestamp_us;
    logic         end_of_packet;
  } ldf_out_item_t;

endpackage

@@ rtl/ldf_stream_if.sv @@
// Valid/ready stream interface used by the deframer's channels.
// Payload type is a parameter; types come from ldf_pkg.
interface ldf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/lidar_packet_deframer.sv @@
// Lidar packet deframer top level: byte stream in, return/timestamp records out.
// Depends on ldf_pkg and ldf_stream_if.
//
// Usage:
//   in_i carries one payload byte per transfer plus a packet_start flag that
//   marks byte 0 of a packet. Each packet is BLOCKS_PER_PACKET blocks of
//   (4 + 3*RETURNS_PER_BLOCK) bytes followed by a 6-byte tail.
//   out_o carries one return record per completed 3-byte return and one
//   timestamp record (end_of_packet set) on the fourth tail byte.
//   cfg_we_i/cfg_wdata_i write min_range_raw; write it only while idle.
// Timing:
//   One byte is taken every cycle while in_i.ready is high. A record caused by a
//   byte is presented on out_o the cycle after that byte's transfer, from a single
//   output register. in_i.ready is high whenever that register is empty or being
//   drained in the same cycle, so a stalled receiver holds the record and stalls
//   the input only while the register is full.
// Reset:
//   rst_ni clears the frame counters and the output valid; min_range_raw
//   returns to 450. The first byte after reset is byte 0 of a packet.
module lidar_packet_deframer
  import ldf_pkg::*;
#(
  parameter int unsigned BLOCKS_PER_PACKET = DefBlocksPerPacket,
  parameter int unsigned RETURNS_PER_BLOCK = DefReturnsPerBlock
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ldf_stream_if.sink   in_i,
  ldf_stream_if.source out_o
);

  localparam int unsigned BlockBytes = HeaderBytes + ReturnBytes * RETURNS_PER_BLOCK;
  localparam int unsigned PosW       = $clog2(BlockBytes);
  localparam int unsigned BlkW       = $clog2(BLOCKS_PER_PACKET + 1);

  // Registers
  logic [15:0]         min_range_q;
  logic [BlkW-1:0]     block_count_q, block_count_d;
  logic [PosW-1:0]     byte_pos_q, byte_pos_d;
  ret_sub_e            sub_q, sub_d;
  logic [RetCntW-1:0]  return_count_q, return_count_d;
  logic [15:0]         held_distance_q, held_distance_d;
  logic [15:0]         held_rotation_q, held_rotation_d;
  logic [31:0]         time_shift_q, time_shift_d;
  logic [TailCntW-1:0] tail_count_q, tail_count_d;
  logic                in_tail_q, in_tail_d;
  logic                out_valid_q, out_valid_d;
  ldf_out_item_t       out_item_q, out_item_d;

  // Effective state after an optional restart
  logic                accept;
  logic                start;
  logic [7:0]          b;
  logic [BlkW-1:0]     blk;
  logic [PosW-1:0]     pos;
  ret_sub_e            sub;
  logic [RetCntW-1:0]  rc;
  logic [TailCntW-1:0] tcnt;
  logic                tail;
  logic                emit;
  logic [31:0]         ts_next;

  assign in_i.ready    = !out_valid_q || out_o.ready;
  assign accept        = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  assign start = in_i.payload.packet_start;
  assign b     = in_i.payload.data_byte;
  assign blk   = start ? '0 : block_count_q;
  assign pos   = start ? '0 : byte_pos_q;
  assign sub   = start ? SUB_DIST_LO : sub_q;
  assign rc    = start ? '0 : return_count_q;
  assign tcnt  = start ? '0 : tail_count_q;
  assign tail  = start ? 1'b0 : in_tail_q;
  assign ts_next = {b, time_shift_q[31:8]};

  // Decode one byte and build the next state and record
  always_comb begin
    block_count_d   = blk;
    byte_pos_d      = pos;
    sub_d           = sub;
    return_count_d  = rc;
    held_distance_d = held_distance_q;
    held_rotation_d = held_rotation_q;
    time_shift_d    = time_shift_q;
    tail_count_d    = tcnt;
    in_tail_d       = tail;
    emit            = 1'b0;
    out_item_d      = '0;

    if (tail) begin
      if (tcnt <= TailCntW'(TsLastByte)) begin
        time_shift_d = ts_next;
      end
      if (tcnt == TailCntW'(TsLastByte)) begin
        emit                     = 1'b1;
        out_item_d.record_kind   = REC_TIMESTAMP;
        out_item_d.timestamp_us  = ts_next;
        out_item_d.end_of_packet = 1'b1;
      end
      if (tcnt < TailCntW'(TailBytes)) begin
        tail_count_d = tcnt + 1'b1;
      end
    end else begin
      if (pos == PosW'(RotLoPos)) begin
        held_rotation_d = {8'h00, b};
      end else if (pos == PosW'(RotHiPos)) begin
        held_rotation_d = {b, held_rotation_q[7:0]};
      end else if (pos >= PosW'(HeaderBytes)) begin
        unique case (sub)
          SUB_DIST_LO: begin
            held_distance_d = {8'h00, b};
            sub_d           = SUB_DIST_HI;
          end
          SUB_DIST_HI: begin
            held_distance_d = {b, held_distance_q[7:0]};
            sub_d           = SUB_INTENS;
          end
          SUB_INTENS: begin
            emit                         = 1'b1;
            out_item_d.record_kind       = REC_RETURN;
            out_item_d.laser_index       = {blk[0], rc};
            out_item_d.column_index      = 3'(blk >> 1);
            out_item_d.rotation_centideg = held_rotation_q;
            out_item_d.distance_mm       = (held_distance_q < min_range_q) ? 17'd0
                                         : {held_distance_q, 1'b0};
            out_item_d.intensity         = b;
            return_count_d               = rc + 1'b1;
            sub_d                        = SUB_DIST_LO;
          end
          default: sub_d = SUB_DIST_LO;
        endcase
      end

      // Advance to the next block, or into the tail after the last one
      if (pos == PosW'(BlockBytes - 1)) begin
        byte_pos_d     = '0;
        return_count_d = '0;
        sub_d          = SUB_DIST_LO;
        block_count_d  = blk + 1'b1;
        if (blk == BlkW'(BLOCKS_PER_PACKET - 1)) begin
          in_tail_d    = 1'b1;
          tail_count_d = '0;
        end
      end else begin
        byte_pos_d = pos + 1'b1;
      end
    end
  end

  // Output slot: load on a transfer in, clear when drained
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q     <= MinRangeRawReset;
      block_count_q   <= '0;
      byte_pos_q      <= '0;
      sub_q           <= SUB_DIST_LO;
      return_count_q  <= '0;
      held_distance_q <= '0;
      held_rotation_q <= '0;
      time_shift_q    <= '0;
      tail_count_q    <= '0;
      in_tail_q       <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        min_range_q <= cfg_wdata_i;
      end
      if (accept) begin
        block_count_q   <= block_count_d;
        byte_pos_q      <= byte_pos_d;
        sub_q           <= sub_d;
        return_count_q  <= return_count_d;
        held_distance_q <= held_distance_d;
        held_rotation_q <= held_rotation_d;
        time_shift_q    <= time_shift_d;
        tail_count_q    <= tail_count_d;
        in_tail_q       <= in_tail_d;
      end
    end
  end

  // Record payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_item_q <= out_item_d;
    end
  end

  // Assertions
  a_tail_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_tail_q |-> (block_count_q == BlkW'(BLOCKS_PER_PACKET)))
    else $error("tail entered with wrong block count");

  a_tail_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_tail_q |-> (tail_count_q == '0))
    else $error("tail counter moved outside the tail");

  a_header_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_pos_q < PosW'(HeaderBytes)) |-> (sub_q == SUB_DIST_LO))
    else $error("return byte phase out of step with block position");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");

  a_ts_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && tail) |=> (out_valid_q && out_item_q.end_of_packet))
    else $error("timestamp record lost");

endmodule

@@ dv/lidar_packet_deframer_tb.sv @@
// Self-checking testbench for lidar_packet_deframer: byte stream in, return and
// timestamp records out, compared against an in-bench predictor.
// Depends on ldf_pkg, ldf_stream_if and the RTL top level.
module lidar_packet_deframer_tb;
  import ldf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Blocks       = DefBlocksPerPacket;
  localparam int unsigned Returns      = DefReturnsPerBlock;
  localparam int unsigned BlockBytes   = HeaderBytes + ReturnBytes * Returns;
  localparam int unsigned PayloadBytes = Blocks * BlockBytes;
  localparam int unsigned PacketBytes  = PayloadBytes + TailBytes;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned FullPhase    = 2;
  localparam int unsigned PhaseBytes   = 24;
  localparam ldf_out_item_t NoRecord   = '0;

  typedef struct {
    logic [7:0]    data;
    logic          start;
    bit            typed;
    ldf_out_item_t rec;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  ldf_stream_if #(.payload_t(ldf_in_item_t))  in_if ();
  ldf_stream_if #(.payload_t(ldf_out_item_t)) out_if ();

  lidar_packet_deframer #(
    .BLOCKS_PER_PACKET(Blocks),
    .RETURNS_PER_BLOCK(Returns)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Deframer mirror: frame position, held fields and threshold
  logic [15:0] threshold_q;
  logic [3:0]  blk_cnt_q;
  logic [6:0]  byte_pos_q;
  logic [4:0]  ret_cnt_q;
  logic [15:0] dist_raw_q;
  logic [15:0] rot_raw_q;
  logic [31:0] ts_shift_q;
  logic [2:0]  tail_cnt_q;
  logic        in_tail_q;

  ldf_out_item_t pending_records[$];
  int unsigned   fail_cnt;
  int unsigned   cycle_cnt;
  int unsigned   bytes_sent;
  int unsigned   returns_seen;
  int unsigned   stamps_seen;
  int unsigned   settings_used;
  bit            tx_idle;
  bit            rx_idle;

  function automatic ldf_out_item_t return_rec(logic [5:0] laser, logic [2:0] col,
                                               logic [15:0] rot, logic [16:0] dist_mm,
                                               logic [7:0] inten);
    ldf_out_item_t r;
    r = '0;
    r.record_kind       = REC_RETURN;
    r.laser_index       = laser;
    r.column_index      = col;
    r.rotation_centideg = rot;
    r.distance_mm       = dist_mm;
    r.intensity         = inten;
    return r;
  endfunction

  // Advance the mirror by one byte; report the record it causes, if any
  task automatic deframe_byte(input logic [7:0] b, input logic start,
                              output logic emits, output ldf_out_item_t rec);
    int unsigned pos;
    rec   = NoRecord;
    emits = 1'b0;
    if (start) begin
      blk_cnt_q  = '0;
      byte_pos_q = '0;
      ret_cnt_q  = '0;
      tail_cnt_q = '0;
      in_tail_q  = 1'b0;
    end
    if (in_tail_q) begin
      if (tail_cnt_q <= TsLastByte) ts_shift_q = {b, ts_shift_q[31:8]};
      if (tail_cnt_q == TsLastByte) begin
        rec.record_kind   = REC_TIMESTAMP;
        rec.timestamp_us  = ts_shift_q;
        rec.end_of_packet = 1'b1;
        emits = 1'b1;
      end
      if (tail_cnt_q < TailBytes) tail_cnt_q = tail_cnt_q + 3'd1;
    end else begin
      pos = byte_pos_q;
      if (pos == RotLoPos) begin
        rot_raw_q = {8'h00, b};
      end else if (pos == RotHiPos) begin
        rot_raw_q[15:8] = b;
      end else if (pos >= HeaderBytes) begin
        case ((pos - HeaderBytes) % ReturnBytes)
          SUB_DIST_LO: dist_raw_q = {8'h00, b};
          SUB_DIST_HI: dist_raw_q[15:8] = b;
          default: begin
            rec.record_kind       = REC_RETURN;
            rec.laser_index       = {blk_cnt_q[0], ret_cnt_q};
            rec.column_index      = blk_cnt_q[3:1];
            rec.rotation_centideg = rot_raw_q;
            rec.distance_mm       = (dist_raw_q < threshold_q) ? 17'd0 : {dist_raw_q, 1'b0};
            rec.intensity         = b;
            emits = 1'b1;
            ret_cnt_q = ret_cnt_q + 5'd1;
          end
        endcase
      end
      byte_pos_q = byte_pos_q + 7'd1;
      if (byte_pos_q >= BlockBytes) begin
        byte_pos_q = '0;
        ret_cnt_q  = '0;
        blk_cnt_q  = blk_cnt_q + 4'd1;
        if (blk_cnt_q >= Blocks) begin
          in_tail_q  = 1'b1;
          tail_cnt_q = '0;
        end
      end
    end
  endtask

  // Offer one byte after a random gap, hold until transferred, then predict
  task automatic send_byte(input logic [7:0] b, input logic start,
                           input bit typed = 1'b0, input ldf_out_item_t typed_rec = NoRecord);
    int unsigned   gap;
    logic          emits;
    ldf_out_item_t rec;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.payload <= '{data_byte: b, packet_start: start};
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    deframe_byte(b, start, emits, rec);
    if (typed) pending_records.push_back(typed_rec);
    else if (emits) pending_records.push_back(rec);
  endtask

  // Drain outstanding records, then write the threshold while the block is idle
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_q = value;
    settings_used++;
  endtask

  // Send the first n bytes of a packet; bytes past the tail make it overlong
  task automatic send_packet(input int unsigned n);
    int unsigned p;
    logic [15:0] word;
    logic [7:0]  b;
    word = '0;
    for (int unsigned i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i < PayloadBytes) begin
        p = i % BlockBytes;
        if (p == RotLoPos) begin
          word = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
          b = word[7:0];
        end else if (p == RotHiPos) begin
          b = word[15:8];
        end else if (p >= HeaderBytes) begin
          case ((p - HeaderBytes) % ReturnBytes)
            SUB_DIST_LO: begin
              case ($urandom_range(0, 3))
                0: word = threshold_q + 16'($urandom_range(0, 2)) - 16'd1;
                1: word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: word = 16'($urandom);
              endcase
              b = word[7:0];
            end
            SUB_DIST_HI: b = word[15:8];
            default: ;
          endcase
        end
      end
      send_byte(b, i == 0);
    end
  endtask

  // Watch the record channel: random stalls, compare each transfer in order
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  initial begin
    int unsigned   stall;
    ldf_out_item_t exp_rec;
    ldf_out_item_t act_rec;
    out_if.ready = 1'b0;
    rx_idle = 1'b1;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
      stall = rx_idle ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      act_rec = out_if.payload;
      if (pending_records.size() == 0) begin
        $error("record transfer with nothing expected: 0x%0h", act_rec);
        fail_cnt++;
      end else begin
        exp_rec = pending_records.pop_front();
        check_field("record_kind", exp_rec.record_kind, act_rec.record_kind);
        check_field("laser_index", exp_rec.laser_index, act_rec.laser_index);
        check_field("column_index", exp_rec.column_index, act_rec.column_index);
        check_field("rotation_centideg", exp_rec.rotation_centideg,
                    act_rec.rotation_centideg);
        check_field("distance_mm", exp_rec.distance_mm, act_rec.distance_mm);
        check_field("intensity", exp_rec.intensity, act_rec.intensity);
        check_field("timestamp_us", exp_rec.timestamp_us, act_rec.timestamp_us);
        check_field("end_of_packet", exp_rec.end_of_packet, act_rec.end_of_packet);
        if (exp_rec.record_kind == REC_TIMESTAMP) stamps_seen++;
        else returns_seen++;
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stim_row_t   stim_rows[22];
    logic [15:0] settings[5];
    int unsigned byte_goal;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    tx_idle        = 1'b1;
    threshold_q    = MinRangeRawReset;
    blk_cnt_q      = '0;
    byte_pos_q     = '0;
    ret_cnt_q      = '0;
    dist_raw_q     = '0;
    rot_raw_q      = '0;
    ts_shift_q     = '0;
    tail_cnt_q     = '0;
    in_tail_q      = 1'b0;
    settings_used  = 1;

    // Directed: stream start without packet_start, rotation and distance
    // extremes, threshold edge at the reset value, early restarts
    stim_rows = '{
      '{8'h00, 1'b0, 1'b0, NoRecord},
      '{8'hFF, 1'b0, 1'b0, NoRecord},
      '{8'hFF, 1'b0, 1'b0, NoRecord},
      '{8'hFF, 1'b0, 1'b0, NoRecord},
      '{8'hC1, 1'b0, 1'b0, NoRecord},
      '{8'h01, 1'b0, 1'b0, NoRecord},
      '{8'hFF, 1'b0, 1'b1, return_rec(6'd0, 3'd0, 16'hFFFF, 17'd0, 8'hFF)},
      '{8'hC2, 1'b0, 1'b0, NoRecord},
      '{8'h01, 1'b0, 1'b0, NoRecord},
      '{8'h00, 1'b0, 1'b1, return_rec(6'd1, 3'd0, 16'hFFFF, 17'd900, 8'h00)},
      '{8'hFF, 1'b0, 1'b0, NoRecord},
      '{8'hFF, 1'b0, 1'b0, NoRecord},
      '{8'h80, 1'b0, 1'b1, return_rec(6'd2, 3'd0, 16'hFFFF, 17'd131070, 8'h80)},
      '{8'h00, 1'b1, 1'b0, NoRecord},
      '{8'h5A, 1'b0, 1'b0, NoRecord},
      '{8'hA0, 1'b0, 1'b0, NoRecord},
      '{8'h8C, 1'b0, 1'b0, NoRecord},
      '{8'h00, 1'b0, 1'b0, NoRecord},
      '{8'h00, 1'b0, 1'b0, NoRecord},
      '{8'h7F, 1'b0, 1'b1, return_rec(6'd0, 3'd0, 16'd36000, 17'd0, 8'h7F)},
      '{8'h55, 1'b1, 1'b0, NoRecord},
      '{8'hAA, 1'b1, 1'b0, NoRecord}
    };
    settings = '{16'h0000, 16'hFFFF, 16'($urandom_range(1, 1000)), 16'd1,
                 16'($urandom)};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i])
      send_byte(stim_rows[i].data, stim_rows[i].start, stim_rows[i].typed, stim_rows[i].rec);

    // Random: each threshold phase sends short packet fragments, each cut off
    // by the next packet_start, and loose noise; one phase also sends a whole
    // packet with a few overlong bytes to reach the tail and timestamp
    foreach (settings[ph]) begin
      write_threshold(settings[ph]);
      if (ph == FullPhase) begin
        tx_idle = 1'b1;
        send_packet(PacketBytes + $urandom_range(1, 4));
      end
      byte_goal = bytes_sent + PhaseBytes;
      while (bytes_sent < byte_goal) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
          0, 1, 2: send_packet($urandom_range(1, 30));
          default: begin
            repeat ($urandom_range(1, 12))
              send_byte(8'($urandom), $urandom_range(0, 7) == 0);
          end
        endcase
      end
    end

    wait_idle();
    $display("Covered %0d byte transfers over %0d threshold settings:", bytes_sent,
             settings_used);
    $display("  %0d return records and %0d timestamp records checked.", returns_seen,
             stamps_seen);
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ldf_pkg.sv
rtl/ldf_stream_if.sv
rtl/lidar_packet_deframer.sv
dv/lidar_packet_deframer_tb.sv
